// ===== rtl/mfb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfb_pkg: shared types, constants and functions of the frame builder
// Holds the command format passed from the front end to the back end, the
// register indexes, the X.25 CRC step and the CRC-extra byte table.
// ----------------------------------------------------------------------------
package mfb_pkg;

  localparam logic [7:0]  START_SIGN = 8'hFE;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;

  localparam logic [7:0] SYS_ID_RST  = 8'hAB;
  localparam logic [7:0] COMP_ID_RST = 8'hCD;
  localparam logic [7:0] MSG_ID_RST  = 8'h00;

  // Configuration register indexes
  localparam logic [1:0] REG_SYS_ID  = 2'd0;
  localparam logic [1:0] REG_COMP_ID = 2'd1;
  localparam logic [1:0] REG_MSG_ID  = 2'd2;

  // Input op codes
  localparam logic OP_START   = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  // Command queue depth, a power of two
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Header byte positions within a start command
  localparam logic [2:0] HDR_SIGN  = 3'd0;
  localparam logic [2:0] HDR_LEN   = 3'd1;
  localparam logic [2:0] HDR_SEQ   = 3'd2;
  localparam logic [2:0] HDR_SYS   = 3'd3;
  localparam logic [2:0] HDR_COMP  = 3'd4;
  localparam logic [2:0] HDR_MSG   = 3'd5;

  typedef enum logic {
    CMD_START   = 1'b0,
    CMD_PAYLOAD = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    logic [7:0] sys_id;
    logic [7:0] comp_id;
    logic [7:0] msg_id;
  } cfg_t;

  // flag: zero length on a start, last payload byte on a payload
  typedef struct packed {
    cmd_kind_t  kind;
    logic       flag;
    logic [7:0] data;
    logic [7:0] seq;
    logic [7:0] sys;
    logic [7:0] comp;
    logic [7:0] msg;
    logic [7:0] extra;
  } cmd_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] t;
    t = b ^ crc[7:0];
    t = t ^ {t[3:0], 4'b0000};
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
  endfunction

  function automatic logic [7:0] crc_extra(input logic [7:0] id);
    logic [7:0] v;
    unique case (id)
      8'd0:   v = 8'd50;
      8'd1:   v = 8'd124;
      8'd2:   v = 8'd137;
      8'd4:   v = 8'd237;
      8'd5:   v = 8'd217;
      8'd6:   v = 8'd104;
      8'd7:   v = 8'd119;
      8'd11:  v = 8'd89;
      8'd20:  v = 8'd214;
      8'd21:  v = 8'd159;
      8'd22:  v = 8'd220;
      8'd23:  v = 8'd168;
      8'd24:  v = 8'd24;
      8'd25:  v = 8'd23;
      8'd26:  v = 8'd170;
      8'd27:  v = 8'd144;
      8'd28:  v = 8'd67;
      8'd29:  v = 8'd115;
      8'd30:  v = 8'd39;
      8'd31:  v = 8'd246;
      8'd32:  v = 8'd185;
      8'd33:  v = 8'd104;
      8'd34:  v = 8'd237;
      8'd35:  v = 8'd244;
      8'd36:  v = 8'd222;
      8'd37:  v = 8'd212;
      8'd38:  v = 8'd9;
      8'd39:  v = 8'd254;
      8'd40:  v = 8'd230;
      8'd41:  v = 8'd28;
      8'd42:  v = 8'd28;
      8'd43:  v = 8'd132;
      8'd44:  v = 8'd221;
      8'd45:  v = 8'd232;
      8'd46:  v = 8'd11;
      8'd47:  v = 8'd153;
      8'd48:  v = 8'd41;
      8'd49:  v = 8'd39;
      8'd50:  v = 8'd214;
      8'd51:  v = 8'd223;
      8'd52:  v = 8'd141;
      8'd53:  v = 8'd33;
      8'd54:  v = 8'd15;
      8'd55:  v = 8'd3;
      8'd56:  v = 8'd100;
      8'd57:  v = 8'd24;
      8'd58:  v = 8'd239;
      8'd59:  v = 8'd238;
      8'd60:  v = 8'd30;
      8'd61:  v = 8'd200;
      8'd62:  v = 8'd183;
      8'd64:  v = 8'd130;
      8'd66:  v = 8'd148;
      8'd67:  v = 8'd21;
      8'd69:  v = 8'd52;
      8'd70:  v = 8'd124;
      8'd74:  v = 8'd20;
      8'd76:  v = 8'd152;
      8'd77:  v = 8'd143;
      8'd89:  v = 8'd231;
      8'd90:  v = 8'd183;
      8'd91:  v = 8'd63;
      8'd92:  v = 8'd54;
      8'd100: v = 8'd175;
      8'd101: v = 8'd102;
      8'd102: v = 8'd158;
      8'd103: v = 8'd208;
      8'd104: v = 8'd56;
      8'd249: v = 8'd204;
      8'd250: v = 8'd49;
      8'd251: v = 8'd170;
      8'd252: v = 8'd44;
      8'd253: v = 8'd83;
      8'd254: v = 8'd46;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/mfb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfb_front: input classifier
// Accepts input items, tracks the open frame and its remaining byte count,
// assigns sequence numbers and pushes start or payload commands to the queue.
// Payload items with no frame open are dropped here.
// ----------------------------------------------------------------------------
module mfb_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  logic          in_op,
  input  logic [7:0]    in_payload_length,
  input  logic [7:0]    in_payload_byte,
  input  mfb_pkg::cfg_t cfg,
  input  logic          q_full,
  output logic          q_push,
  output mfb_pkg::cmd_t q_wdata
);

  logic       accept;
  logic [7:0] seq_r, seq_nxt;
  logic [7:0] remain_r, remain_nxt;
  logic       open_r, open_nxt;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  always_comb begin
    seq_nxt    = seq_r;
    remain_nxt = remain_r;
    open_nxt   = open_r;
    q_push     = 1'b0;
    q_wdata.kind  = mfb_pkg::CMD_START;
    q_wdata.flag  = 1'b0;
    q_wdata.data  = in_payload_length;
    q_wdata.seq   = seq_r;
    q_wdata.sys   = cfg.sys_id;
    q_wdata.comp  = cfg.comp_id;
    q_wdata.msg   = cfg.msg_id;
    q_wdata.extra = mfb_pkg::crc_extra(cfg.msg_id);
    if (accept) begin
      if (in_op == mfb_pkg::OP_START) begin
        // an open frame is simply abandoned
        q_push       = 1'b1;
        q_wdata.flag = (in_payload_length == 8'd0);
        seq_nxt      = seq_r + 8'd1;
        remain_nxt   = in_payload_length;
        open_nxt     = (in_payload_length != 8'd0);
      end else if (open_r) begin
        q_push       = 1'b1;
        q_wdata.kind = mfb_pkg::CMD_PAYLOAD;
        q_wdata.data = in_payload_byte;
        q_wdata.flag = (remain_r == 8'd1);
        remain_nxt   = remain_r - 8'd1;
        open_nxt     = (remain_r != 8'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r    <= 8'd0;
      remain_r <= 8'd0;
      open_r   <= 1'b0;
    end else begin
      seq_r    <= seq_nxt;
      remain_r <= remain_nxt;
      open_r   <= open_nxt;
    end
  end

  a_open_count: assert property (@(posedge clk) disable iff (!rst_n)
    open_r == (remain_r != 8'd0))
    else $error("frame open flag disagrees with remaining count");

  a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == mfb_pkg::OP_START) |=> (seq_r == $past(seq_r) + 8'd1))
    else $error("sequence number did not advance on start");

endmodule

// ===== rtl/mfb_cmd_q.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfb_cmd_q: command queue
// Short first-in first-out buffer of commands between the front end and the
// serializing back end, so that each side stalls on its own.
// ----------------------------------------------------------------------------
module mfb_cmd_q (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mfb_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output mfb_pkg::cmd_t rdata,
  output logic          empty
);

  mfb_pkg::cmd_t                mem [mfb_pkg::Q_DEPTH];
  logic [mfb_pkg::Q_AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [mfb_pkg::Q_CW-1:0]     cnt_r;
  logic                         do_push, do_pop;

  assign full    = (cnt_r == mfb_pkg::Q_CW'(mfb_pkg::Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= mfb_pkg::Q_CW'(mfb_pkg::Q_DEPTH))
    else $error("command queue count out of range");

endmodule

// ===== rtl/mfb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfb_back: frame serializer
// Takes commands from the queue, emits frame bytes one per cycle while the
// output register is empty or popped: header bytes for a start, the echoed
// payload byte, and two CRC bytes when a frame closes. Runs the X.25 CRC.
// ----------------------------------------------------------------------------
module mfb_back (
  input  logic          clk,
  input  logic          rst_n,
  input  mfb_pkg::cmd_t q_head,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          out_empty,
  input  logic          out_pop,
  output logic [7:0]    out_frame_byte,
  output logic          out_end_of_frame
);

  typedef enum logic [2:0] {
    ST_CMD    = 3'b001,
    ST_CRC_LO = 3'b010,
    ST_CRC_HI = 3'b100
  } bk_state_t;

  bk_state_t   state_r, state_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  extra_r, extra_nxt;
  logic        out_valid_r;
  logic [7:0]  out_byte_r, byte_nxt;
  logic        out_eof_r, eof_nxt;
  logic        adv, emit;
  logic [7:0]  hdr_byte;
  logic [15:0] crc_fin;

  assign adv              = !out_valid_r || out_pop;
  assign out_empty        = !out_valid_r;
  assign out_frame_byte   = out_byte_r;
  assign out_end_of_frame = out_eof_r;
  assign crc_fin          = mfb_pkg::crc_feed(crc_r, extra_r);

  always_comb begin
    case (idx_r)
      mfb_pkg::HDR_SIGN: hdr_byte = mfb_pkg::START_SIGN;
      mfb_pkg::HDR_LEN:  hdr_byte = q_head.data;
      mfb_pkg::HDR_SEQ:  hdr_byte = q_head.seq;
      mfb_pkg::HDR_SYS:  hdr_byte = q_head.sys;
      mfb_pkg::HDR_COMP: hdr_byte = q_head.comp;
      mfb_pkg::HDR_MSG:  hdr_byte = q_head.msg;
      default:           hdr_byte = q_head.msg;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    crc_nxt   = crc_r;
    extra_nxt = extra_r;
    byte_nxt  = out_byte_r;
    eof_nxt   = 1'b0;
    emit      = 1'b0;
    q_pop     = 1'b0;
    unique case (state_r)
      ST_CMD: begin
        if (adv && !q_empty) begin
          emit = 1'b1;
          if (q_head.kind == mfb_pkg::CMD_START) begin
            byte_nxt = hdr_byte;
            if (idx_r == mfb_pkg::HDR_SIGN) begin
              // start sign stays out of the CRC
              crc_nxt   = mfb_pkg::CRC_INIT;
              extra_nxt = q_head.extra;
            end else begin
              crc_nxt = mfb_pkg::crc_feed(crc_r, hdr_byte);
            end
            if (idx_r == mfb_pkg::HDR_MSG) begin
              q_pop   = 1'b1;
              idx_nxt = mfb_pkg::HDR_SIGN;
              if (q_head.flag) begin
                state_nxt = ST_CRC_LO;
              end
            end else begin
              idx_nxt = idx_r + 3'd1;
            end
          end else begin
            byte_nxt = q_head.data;
            crc_nxt  = mfb_pkg::crc_feed(crc_r, q_head.data);
            q_pop    = 1'b1;
            if (q_head.flag) begin
              state_nxt = ST_CRC_LO;
            end
          end
        end
      end
      ST_CRC_LO: begin
        if (adv) begin
          emit      = 1'b1;
          byte_nxt  = crc_fin[7:0];
          crc_nxt   = crc_fin;
          state_nxt = ST_CRC_HI;
        end
      end
      ST_CRC_HI: begin
        if (adv) begin
          emit      = 1'b1;
          byte_nxt  = crc_r[15:8];
          eof_nxt   = 1'b1;
          state_nxt = ST_CMD;
        end
      end
      default: state_nxt = ST_CMD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CMD;
      idx_r       <= mfb_pkg::HDR_SIGN;
      crc_r       <= mfb_pkg::CRC_INIT;
      extra_r     <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      crc_r   <= crc_nxt;
      extra_r <= extra_nxt;
      if (adv) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte_r <= byte_nxt;
      out_eof_r  <= eof_nxt;
    end
  end

  a_crc_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && state_r == ST_CRC_LO) |=> (out_valid_r && !out_eof_r && state_r == ST_CRC_HI))
    else $error("CRC low byte not followed by CRC high byte");

  a_sign_first: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && state_r == ST_CMD && q_head.kind == mfb_pkg::CMD_START &&
     idx_r == mfb_pkg::HDR_SIGN) |=> (out_byte_r == mfb_pkg::START_SIGN && !out_eof_r))
    else $error("frame did not open with the start sign");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= mfb_pkg::HDR_MSG)
    else $error("header byte index out of range");

endmodule

// ===== rtl/mavlink_frame_builder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavlink_frame_builder_core: MAVLink v1 frame serializer
// Builds frames with header, echoed payload and X.25 CRC from start and
// payload items; holds the system, component and message id registers.
// ----------------------------------------------------------------------------
// The input side takes one item per cycle while the command queue has room;
// each item turns into output bytes that leave the back end's output register
// at one byte per cycle while out_pop keeps it drained. A start item yields
// six header bytes (eight for an empty frame), a payload item one byte, and
// the last payload byte of a frame three bytes with the CRC. The input side
// can accept new items while the back end is still busy with earlier ones;
// the four-entry command queue absorbs input during that time. An accepted
// item is first written into the command queue, and its first byte is then
// registered into the back end's output register.
// ----------------------------------------------------------------------------
module mavlink_frame_builder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic       in_op,
  input  logic [7:0] in_payload_length,
  input  logic [7:0] in_payload_byte,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_frame_byte,
  output logic       out_end_of_frame,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  mfb_pkg::cfg_t cfg_r;
  mfb_pkg::cmd_t q_wdata, q_head;
  logic          q_push, q_full, q_pop, q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sys_id  <= mfb_pkg::SYS_ID_RST;
      cfg_r.comp_id <= mfb_pkg::COMP_ID_RST;
      cfg_r.msg_id  <= mfb_pkg::MSG_ID_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        mfb_pkg::REG_SYS_ID:  cfg_r.sys_id  <= cfg_wdata;
        mfb_pkg::REG_COMP_ID: cfg_r.comp_id <= cfg_wdata;
        mfb_pkg::REG_MSG_ID:  cfg_r.msg_id  <= cfg_wdata;
        default: ; // unmapped index: drop the write
      endcase
    end
  end

  mfb_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_op             (in_op),
    .in_payload_length (in_payload_length),
    .in_payload_byte   (in_payload_byte),
    .cfg               (cfg_r),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_wdata           (q_wdata)
  );

  mfb_cmd_q u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_head),
    .empty (q_empty)
  );

  mfb_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_head           (q_head),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_frame_byte   (out_frame_byte),
    .out_end_of_frame (out_end_of_frame)
  );

endmodule
